### rtl/esc_pkg.sv
package esc_pkg;

  // Pipeline depth and placement of the bit-serial pressure divider
  localparam int STAGES    = 52;
  localparam int DIV_FIRST = 12;
  localparam int DIV_BITS  = 32;

  // Configuration register indexes (byte address is 8 * index)
  localparam logic [2:0] REG_TEMP      = 3'd0;
  localparam logic [2:0] REG_PRESS_LO  = 3'd1;
  localparam logic [2:0] REG_PRESS_HI  = 3'd2;
  localparam logic [2:0] REG_PRESS_HUM = 3'd3;
  localparam logic [2:0] REG_HUM       = 3'd4;

  // Reciprocal of 133322 / 1e6 in Q20, rounded down
  localparam logic [22:0] MMHG_RECIP = 23'd7864988;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } esc_in_t;

  typedef struct packed {
    logic signed [14:0] temp_centi_c;
    logic signed [15:0] temp_centi_f;
    logic [16:0]        pressure_pa;
    logic [19:0]        pressure_milli_mmhg;
    logic [16:0]        humidity_q10;
    logic [16:0]        humidity_milli_pct;
  } esc_out_t;

  // Working set carried down the pipeline
  typedef struct packed {
    logic [19:0]        adc_p;
    logic [15:0]        adc_h;
    logic signed [31:0] t_x;
    logic signed [31:0] t_y;
    logic [35:0]        t_prod;
    logic               t_neg;
    logic signed [14:0] tc;
    logic signed [15:0] tfh;
    logic signed [31:0] h_a;
    logic signed [31:0] h_b;
    logic signed [31:0] h_e;
    logic signed [31:0] h_x;
    logic signed [31:0] h_y;
    logic signed [31:0] h_c;
    logic [16:0]        hum;
    logic [16:0]        hum_m;
    logic signed [31:0] p_a;
    logic signed [31:0] p_q;
    logic signed [31:0] p_b;
    logic signed [31:0] p_c;
    logic signed [31:0] p_d;
    logic signed [31:0] p_x;
    logic signed [31:0] p_y;
    logic [31:0]        p_v;
    logic               pmsb;
    logic [31:0]        d_div;
    logic [31:0]        d_rem;
    logic [31:0]        d_nq;
    logic               pzero;
    logic [31:0]        p_u;
    logic [31:0]        p_sq;
    logic signed [31:0] p_s;
    logic [16:0]        press;
    logic [39:0]        mm_est;
    logic [36:0]        mm_exact;
    logic [19:0]        mm_q0;
    logic [37:0]        mm_qp;
    logic [19:0]        mm;
  } esc_pipe_t;

  // Signed divide by 2^sh, truncating toward zero
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
                                                 input int unsigned sh);
    logic [31:0] bias;
    bias = x[31] ? ((32'd1 << sh) - 32'd1) : 32'd0;
    return (x + $signed(bias)) >>> sh;
  endfunction

  // 32-bit wrapping signed product
  function automatic logic signed [31:0] mulw(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return $signed(p[31:0]);
  endfunction

endpackage

### rtl/env_sensor_compensation_core.sv
// Environmental sensor compensation core.
// Input channel (in_valid / in_stall / in_data) takes one raw temperature,
// pressure and humidity reading per transfer. Output channel (out_valid /
// out_stall / out_data) returns compensated temperature (0.01 C, 0.01 F),
// pressure (Pa, 0.001 mmHg) and humidity (Q7.10, 0.001 %RH), one result
// per reading, in order.
// Calibration coefficients are written over the APB-style port at byte
// address 8 * index, 64-bit data; write them only while no reading is in
// flight.
// There are 52 register stages, and one reading is taken every cycle while
// in_stall is low. The depth is set by the 32-stage bit-per-stage pressure
// divider plus the multiplier stages.
// Each stage advances when it is empty or the stage after it advances, so
// with out_stall high the last result holds and bubbles further up still
// fill; in_stall rises only once every stage holds a reading.
// Reset (rst, synchronous) empties the pipeline and clears every
// coefficient to zero, for which pressure reads 30000 Pa.
module env_sensor_compensation_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  esc_pkg::esc_in_t       in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output esc_pkg::esc_out_t      out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [5:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);
  import esc_pkg::*;

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_lo;
  logic [63:0] press_coeffs_hi;
  logic [47:0] press_last_hum_first;
  logic [31:0] hum_coeffs;

  logic signed [31:0] t1, t2, t3;
  logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [31:0] h1, h2, h3, h5, h6;

  esc_pipe_t          st [STAGES];
  esc_pipe_t          nx [STAGES];
  logic [STAGES-1:0]  vld;
  logic [STAGES-1:0]  en;

  // Register write and read back
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs          <= '0;
      press_coeffs_lo      <= '0;
      press_coeffs_hi      <= '0;
      press_last_hum_first <= '0;
      hum_coeffs           <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[5:3])
        REG_TEMP:      temp_coeffs          <= pwdata[47:0];
        REG_PRESS_LO:  press_coeffs_lo      <= pwdata;
        REG_PRESS_HI:  press_coeffs_hi      <= pwdata;
        REG_PRESS_HUM: press_last_hum_first <= pwdata[47:0];
        REG_HUM:       hum_coeffs           <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_TEMP:      prdata = {16'b0, temp_coeffs};
      REG_PRESS_LO:  prdata = press_coeffs_lo;
      REG_PRESS_HI:  prdata = press_coeffs_hi;
      REG_PRESS_HUM: prdata = {16'b0, press_last_hum_first};
      REG_HUM:       prdata = {32'b0, hum_coeffs};
      default:       prdata = '0;
    endcase
  end

  // Unpack coefficients to 32-bit signed operands
  assign t1 = $signed({16'b0, temp_coeffs[15:0]});
  assign t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
  assign t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
  assign p1 = $signed({16'b0, press_coeffs_lo[15:0]});
  assign p2 = {{16{press_coeffs_lo[31]}}, press_coeffs_lo[31:16]};
  assign p3 = {{16{press_coeffs_lo[47]}}, press_coeffs_lo[47:32]};
  assign p4 = {{16{press_coeffs_lo[63]}}, press_coeffs_lo[63:48]};
  assign p5 = {{16{press_coeffs_hi[15]}}, press_coeffs_hi[15:0]};
  assign p6 = {{16{press_coeffs_hi[31]}}, press_coeffs_hi[31:16]};
  assign p7 = {{16{press_coeffs_hi[47]}}, press_coeffs_hi[47:32]};
  assign p8 = {{16{press_coeffs_hi[63]}}, press_coeffs_hi[63:48]};
  assign p9 = {{16{press_last_hum_first[15]}}, press_last_hum_first[15:0]};
  assign h1 = $signed({24'b0, press_last_hum_first[23:16]});
  assign h2 = {{16{press_last_hum_first[39]}}, press_last_hum_first[39:24]};
  assign h3 = $signed({24'b0, press_last_hum_first[47:40]});
  assign h5 = {{20{hum_coeffs[23]}}, hum_coeffs[23:12]};
  assign h6 = {{24{hum_coeffs[31]}}, hum_coeffs[31:24]};

  // Stage logic: each stage starts from the one before and updates its fields
  always_comb begin
    logic signed [31:0] w;
    logic signed [31:0] tcx;
    logic signed [31:0] hq;
    logic [15:0]        q16;
    logic [32:0]        rem33;
    logic               qbit;
    logic [31:0]        pfull;
    logic [31:0]        p8th;
    logic [31:0]        psum;

    nx[0] = '0;
    for (int k = 1; k < STAGES; k++) begin
      nx[k] = st[k-1];
    end

    // Stage 0: capture reading, first temperature differences
    nx[0].adc_p = in_data.raw_pressure;
    nx[0].adc_h = in_data.raw_humidity;
    nx[0].t_x   = $signed({15'b0, in_data.raw_temperature[19:3]}) - (t1 <<< 1);
    nx[0].t_y   = $signed({16'b0, in_data.raw_temperature[19:4]}) - t1;

    // Stages 1 to 3: fine temperature
    nx[1].t_x = mulw(st[0].t_x, t2);
    nx[1].t_y = mulw(st[0].t_y, st[0].t_y);
    nx[2].t_x = sdiv_p2(st[1].t_x, 11);
    nx[2].t_y = mulw(sdiv_p2(st[1].t_y, 12), t3);
    nx[3].t_x = st[2].t_x + sdiv_p2(st[2].t_y, 14);

    // Stage 4: Celsius with clamp, humidity and pressure offsets
    w   = (st[3].t_x <<< 2) + st[3].t_x + 32'sd128;
    w   = sdiv_p2(w, 8);
    if (w < -32'sd4000) begin
      w = -32'sd4000;
    end else if (w > 32'sd8500) begin
      w = 32'sd8500;
    end
    nx[4].tc  = w[14:0];
    nx[4].h_a = st[3].t_x - 32'sd76800;
    nx[4].p_a = sdiv_p2(st[3].t_x, 1) - 32'sd64000;

    // Stage 5: Fahrenheit numerator, humidity and pressure products
    tcx = {{17{st[4].tc[14]}}, st[4].tc};
    w   = (tcx <<< 4) + (tcx <<< 1) + 32'sd32000;
    nx[5].t_neg = w[31];
    nx[5].t_x   = w[31] ? -w : w;
    nx[5].h_x   = mulw(h5, st[4].h_a);
    nx[5].h_y   = mulw(st[4].h_a, h6);
    nx[5].h_b   = mulw(st[4].h_a, h3);
    nx[5].p_q   = sdiv_p2(st[4].p_a, 2);

    // Stage 6
    nx[6].t_prod = {18'b0, st[5].t_x[17:0]} * 36'd52429;
    w = $signed({2'b0, st[5].adc_h, 14'b0}) - $signed({hum_coeffs[11:0], 20'b0})
        - st[5].h_x + 32'sd16384;
    nx[6].h_e = sdiv_p2(w, 15);
    nx[6].h_y = sdiv_p2(st[5].h_y, 10);
    nx[6].h_b = sdiv_p2(st[5].h_b, 11) + 32'sd32768;
    nx[6].p_x = mulw(st[5].p_q, st[5].p_q);
    nx[6].p_y = mulw(st[5].p_a, p5);
    nx[6].p_d = mulw(p2, st[5].p_a);

    // Stage 7: divide by ten by reciprocal, exact below 2^18
    q16 = st[6].t_prod[34:19];
    nx[7].tfh = st[6].t_neg ? -$signed(q16) : $signed(q16);
    nx[7].h_x = mulw(st[6].h_y, st[6].h_b);
    nx[7].p_b = mulw(sdiv_p2(st[6].p_x, 11), p6);
    nx[7].p_c = mulw(p3, sdiv_p2(st[6].p_x, 13));
    nx[7].p_y = st[6].p_y <<< 1;
    nx[7].p_d = sdiv_p2(st[6].p_d, 1);

    // Stage 8
    nx[8].h_x = sdiv_p2(st[7].h_x, 10) + 32'sd2097152;
    nx[8].p_b = sdiv_p2(st[7].p_b + st[7].p_y, 2) + $signed({p4[15:0], 16'b0});
    nx[8].p_c = sdiv_p2(st[7].p_c, 3) + st[7].p_d;

    // Stage 9
    nx[9].h_x = mulw(st[8].h_x, h2);
    nx[9].p_c = sdiv_p2(st[8].p_c, 18) + 32'sd32768;
    nx[9].p_v = (32'd1048576 - {12'b0, st[8].adc_p})
                - $unsigned(sdiv_p2(st[8].p_b, 12));

    // Stage 10
    nx[10].h_x = sdiv_p2(st[9].h_x + 32'sd8192, 14);
    nx[10].p_c = mulw(st[9].p_c, p1);
    nx[10].p_v = st[9].p_v * 32'd3125;

    // Stage 11: load divider
    nx[11].h_c   = mulw(st[10].h_e, st[10].h_x);
    nx[11].d_div = $unsigned(sdiv_p2(st[10].p_c, 15));
    nx[11].pmsb  = st[10].p_v[31];
    nx[11].d_nq  = st[10].p_v[31] ? st[10].p_v : {st[10].p_v[30:0], 1'b0};
    nx[11].d_rem = '0;

    // Stages 12 to 15: humidity tail
    hq = sdiv_p2(st[11].h_c, 15);
    nx[12].h_y = mulw(hq, hq);
    nx[13].h_y = mulw(sdiv_p2(st[12].h_y, 7), h1);
    w = st[13].h_c - sdiv_p2(st[13].h_y, 4);
    if (w < 32'sd0) begin
      w = 32'sd0;
    end else if (w > 32'sd419430400) begin
      w = 32'sd419430400;
    end
    nx[14].hum = w[28:12];
    nx[15].hum_m = 17'(({10'b0, st[14].hum} * 27'd1000) >> 10);

    // Divider: one quotient bit per stage, restoring
    for (int k = DIV_FIRST; k < DIV_FIRST + DIV_BITS; k++) begin
      rem33 = {st[k-1].d_rem, st[k-1].d_nq[31]};
      qbit  = rem33 >= {1'b0, st[k-1].d_div};
      if (qbit) begin
        rem33 = rem33 - {1'b0, st[k-1].d_div};
      end
      nx[k].d_rem = rem33[31:0];
      nx[k].d_nq  = {st[k-1].d_nq[30:0], qbit};
    end

    // Stage 44: undo the pre-scale
    pfull = st[43].pmsb ? {st[43].d_nq[30:0], 1'b0} : st[43].d_nq;
    nx[44].p_u   = pfull;
    nx[44].pzero = st[43].d_div == 32'd0;

    // Stages 45 to 48: pressure correction and clamp
    p8th = {3'b0, st[44].p_u[31:3]};
    nx[45].p_sq = p8th * p8th;
    nx[45].p_d  = mulw($signed({2'b0, st[44].p_u[31:2]}), p8);
    nx[46].p_c  = mulw(p9, $signed({13'b0, st[45].p_sq[31:13]}));
    nx[46].p_d  = sdiv_p2(st[45].p_d, 13);
    nx[47].p_s  = sdiv_p2(sdiv_p2(st[46].p_c, 12) + st[46].p_d + p7, 4);
    psum = st[47].p_u + $unsigned(st[47].p_s);
    if (st[47].pzero || psum < 32'd30000) begin
      nx[48].press = 17'd30000;
    end else if (psum > 32'd110000) begin
      nx[48].press = 17'd110000;
    end else begin
      nx[48].press = psum[16:0];
    end

    // Stages 49 to 51: mmHg by reciprocal with one correction step
    nx[49].mm_est   = {17'b0, st[48].press} * {17'b0, MMHG_RECIP};
    nx[49].mm_exact = {20'b0, st[48].press} * 37'd1000000;
    nx[50].mm_q0    = st[49].mm_est[39:20];
    nx[50].mm_qp    = ({18'b0, st[49].mm_est[39:20]} + 38'd1) * 38'd133322;
    nx[51].mm = ({1'b0, st[50].mm_exact} >= st[50].mm_qp) ? st[50].mm_q0 + 20'd1
                                                            : st[50].mm_q0;
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  // Hold payload unless the stage advances
  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (en[k]) begin
        st[k] <= nx[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Drive result transfer from the last stage
  assign out_valid                    = vld[STAGES-1];
  assign out_data.temp_centi_c        = st[STAGES-1].tc;
  assign out_data.temp_centi_f        = st[STAGES-1].tfh;
  assign out_data.pressure_pa         = st[STAGES-1].press;
  assign out_data.pressure_milli_mmhg = st[STAGES-1].mm;
  assign out_data.humidity_q10        = st[STAGES-1].hum;
  assign out_data.humidity_milli_pct  = st[STAGES-1].hum_m;

endmodule
